// File: rtl/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg: shared types and constants of the selectable smoothing filter
// Register indexes, reset values, fixed arithmetic widths and the sequencer
// state type.
// ----------------------------------------------------------------------------
package ssf_pkg;

   // Fixed arithmetic of the filter.
   localparam int SUM_BITS   = 25;
   localparam int GAIN_SHIFT = 16;
   localparam int GAIN_W     = 17;
   localparam int WIN_W      = 9;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

   // Configuration port.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 17;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MODE   = 2'd0,
      CSR_WINDOW = 2'd1,
      CSR_GAIN   = 2'd2
   } csr_index_type;

   localparam logic              MODE_MAVG    = 1'b0;
   localparam logic              MODE_EXP     = 1'b1;
   localparam logic [WIN_W-1:0]  WINDOW_RESET = 9'd16;
   localparam logic [GAIN_W-1:0] GAIN_RESET   = 17'd32768;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUM  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

// File: rtl/ssf_divider.sv
// ----------------------------------------------------------------------------
// ssf_divider: restoring unsigned divider
// Produces one quotient bit per cycle; done pulses for one cycle when the
// quotient is ready, and the quotient holds until the next start.
// ----------------------------------------------------------------------------
module ssf_divider #(
   parameter int DIVIDEND_W = 25,
   parameter int DIVISOR_W  = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dsr_ff;
   logic [DIVIDEND_W-1:0] quo_ff;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // Bring down the next dividend bit and try the subtraction.
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
         rem_ff <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/selectable_smoothing_filter.sv
// ----------------------------------------------------------------------------
// selectable_smoothing_filter: moving-average / exponential smoothing filter
// One smoothed sample per input sample, selected by the mode register.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the req_ stream (tdata holds the sample, tlast marks the
//   last sample of a record) and leave on the rsp_ stream, one result
//   transaction per input transaction, with tlast copied through.
//   Mode 0 averages the last window_length samples of the record, counting
//   samples before the record start as zero; mode 1 runs first-order
//   exponential smoothing seeded with the first sample of the record.
//   After a sample flagged with tlast, all record state returns to its start.
//   An accepted sample passes the sum state, in mode 0 the divide state, and
//   the done state, from which the result is registered into the output
//   register that drives rsp_tvalid. The block takes one sample at a time: in
//   mode 0 each sample waits on the 25-step serial divider for the window
//   mean; in mode 1 on the delay memory read and the registered gain multiply.
//   The result sits in an output register; a stalled receiver holds it there
//   and the block holds its finished next result until that register frees.
//   Synchronous reset clears the configuration to its defaults and the record
//   state; the delay memory is not cleared, since entries are only used after
//   they were written in the current record. The user must write configuration
//   through csr_we/csr_addr/csr_wdata only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module selectable_smoothing_filter
   import ssf_pkg::*;
#(
   parameter int MAX_WINDOW  = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,  // [SAMPLE_BITS-1:0] sample_in
   input  logic                                req_tlast,  // last_in_record
   // Result stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]    rsp_tdata,  // [SAMPLE_BITS-1:0] sample_out
   output logic                                rsp_tlast,  // last_out
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [CSR_ADDR_W-1:0]               csr_addr,
   input  logic [CSR_DATA_W-1:0]               csr_wdata
);

   localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int PTR_W   = $clog2(MAX_WINDOW);
   localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
   localparam int LEN_W   = (FILL_W > WIN_W) ? FILL_W : WIN_W;
   localparam int ACC_W   = ((SAMPLE_BITS > SUM_BITS) ? SAMPLE_BITS : SUM_BITS) + 1;
   localparam int DIFF_W  = SAMPLE_BITS + 1;
   localparam int PROD_W  = DIFF_W + GAIN_W + 1;
   localparam int EXP_W   = SAMPLE_BITS + 2;
   localparam int CL_W    = (EXP_W > SUM_BITS + 1) ? EXP_W : SUM_BITS + 1;

   localparam logic signed [CL_W-1:0] SAT_HI =
      {{(CL_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [CL_W-1:0] SAT_LO = ~SAT_HI;

   // Configuration registers.
   logic                          mode_ff;
   logic [WIN_W-1:0]              window_ff;
   logic [GAIN_W-1:0]             gain_ff;

   // Sequencer and captured input.
   state_type                     state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic                          last_ff;

   // Delay memory and record state.
   logic [SAMPLE_BITS-1:0]        delay_mem [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic signed [SUM_BITS-1:0]    sum_ff;
   logic [PTR_W-1:0]              wp_ff;
   logic [FILL_W-1:0]             fill_ff;
   logic signed [SAMPLE_BITS-1:0] prev_ff;
   logic                          fresh_ff;

   // Datapath registers.
   logic                          neg_ff;
   logic signed [PROD_W-1:0]      prod_ff;

   // Output register.
   logic                          rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]        rsp_sample_ff;
   logic                          rsp_last_ff;

   // Combinational datapath.
   logic                          accept;
   logic                          advance;
   logic [LEN_W-1:0]              win_ext;
   logic [LEN_W-1:0]              len_eff;
   logic [LEN_W-1:0]              wp_ext;
   logic [LEN_W-1:0]              rd_addr_wide;
   logic [PTR_W-1:0]              rd_addr;
   logic                          drop;
   logic signed [ACC_W-1:0]       acc;
   logic signed [SUM_BITS-1:0]    sum_next;
   logic [SUM_BITS-1:0]           sum_mag;
   logic [GAIN_W-1:0]             gain_eff;
   logic signed [DIFF_W-1:0]      diff;
   logic signed [GAIN_W:0]        gain_s;
   logic signed [PROD_W-1:0]      prod_next;
   logic signed [EXP_W-1:0]       step_val;
   logic signed [EXP_W-1:0]       exp_sum;
   logic                          div_start;
   logic                          div_done;
   logic [SUM_BITS-1:0]           div_quo;
   logic signed [CL_W-1:0]        q_val;
   logic signed [SAMPLE_BITS-1:0] y_next;

   function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(
      input logic signed [CL_W-1:0] v
   );
      logic signed [SAMPLE_BITS-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[SAMPLE_BITS-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         r = v[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign advance    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // ------------------------------------------------------------------------
   // Configuration writes. An index beyond the register list is ignored.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_MAVG;
         window_ff <= WINDOW_RESET;
         gain_ff   <= GAIN_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MODE: begin
               mode_ff <= csr_wdata[0];
            end
            CSR_WINDOW: begin
               window_ff <= csr_wdata[WIN_W-1:0];
            end
            CSR_GAIN: begin
               gain_ff <= csr_wdata[GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Window bookkeeping. A window of zero acts as one and a window above the
   // memory depth acts as the full depth. The oldest sample in the window
   // lies window entries behind the write pointer, modulo the depth.
   // ------------------------------------------------------------------------
   always_comb begin
      win_ext = LEN_W'(window_ff);
      if (win_ext == '0) begin
         len_eff = LEN_W'(1);
      end else if (win_ext > LEN_W'(MAX_WINDOW)) begin
         len_eff = LEN_W'(MAX_WINDOW);
      end else begin
         len_eff = win_ext;
      end
   end

   assign wp_ext       = LEN_W'(wp_ff);
   assign rd_addr_wide = (wp_ext >= len_eff) ? (wp_ext - len_eff)
                                             : (wp_ext + LEN_W'(MAX_WINDOW) - len_eff);
   assign rd_addr      = rd_addr_wide[PTR_W-1:0];

   // Only once the window has filled within this record does a sample drop
   // out of the sum, so the entry read is always one of this record.
   assign drop = (LEN_W'(fill_ff) >= len_eff);

   // The read is issued as the sample is accepted; its data is used in the
   // following cycle, where the new sample is written at the write pointer.
   // The two addresses coincide only when the window is the full depth.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= delay_mem[rd_addr];
      end
      if (state_ff == ST_SUM) begin
         delay_mem[wp_ff] <= x_ff;
      end
   end

   // Running sum update: add the new sample, drop the oldest, wrap to 25 bits.
   assign acc      = ACC_W'(sum_ff) + ACC_W'(x_ff) - (drop ? ACC_W'(rd_data_ff) : '0);
   assign sum_next = acc[SUM_BITS-1:0];
   assign sum_mag  = sum_next[SUM_BITS-1] ? (~sum_next + 1'b1) : sum_next;

   // Exponential smoothing: the product is registered, then shifted by the
   // gain's fraction bits with floor rounding and added to the last output.
   assign gain_eff  = (gain_ff > GAIN_ONE) ? GAIN_ONE : gain_ff;
   assign gain_s    = $signed({1'b0, gain_eff});
   assign diff      = DIFF_W'(x_ff) - DIFF_W'(prev_ff);
   assign prod_next = PROD_W'(diff) * PROD_W'(gain_s);
   assign step_val  = EXP_W'(prod_ff >>> GAIN_SHIFT);
   assign exp_sum   = EXP_W'(prev_ff) + step_val;

   // The mean is formed from the magnitude and the sign restored, which
   // truncates toward zero.
   assign div_start = (state_ff == ST_SUM) && (mode_ff == MODE_MAVG);

   ssf_divider #(
      .DIVIDEND_W (SUM_BITS),
      .DIVISOR_W  (LEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (len_eff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign q_val = neg_ff ? -$signed(CL_W'(div_quo)) : $signed(CL_W'(div_quo));

   always_comb begin
      if (mode_ff == MODE_MAVG) begin
         y_next = clamp_sample(q_val);
      end else if (fresh_ff) begin
         y_next = x_ff;
      end else begin
         y_next = clamp_sample(CL_W'(exp_sum));
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = (mode_ff == MODE_MAVG) ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= req_tdata[SAMPLE_BITS-1:0];
         last_ff <= req_tlast;
      end
      if (state_ff == ST_SUM) begin
         neg_ff  <= sum_next[SUM_BITS-1];
         prod_ff <= prod_next;
      end
   end

   // Record state: updated once per sample, cleared after the last sample
   // of a record has been filtered.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         wp_ff    <= '0;
         fill_ff  <= '0;
         prev_ff  <= '0;
         fresh_ff <= 1'b1;
      end else if (state_ff == ST_SUM) begin
         sum_ff <= sum_next;
         wp_ff  <= (wp_ff == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_ff + 1'b1;
         if (fill_ff < FILL_W'(MAX_WINDOW)) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end else if (advance) begin
         if (last_ff) begin
            sum_ff   <= '0;
            wp_ff    <= '0;
            fill_ff  <= '0;
            prev_ff  <= '0;
            fresh_ff <= 1'b1;
         end else begin
            prev_ff  <= y_next;
            fresh_ff <= 1'b0;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_sample_ff <= y_next;
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_sample_ff);
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   a_done_in_div : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_WINDOW))
      else $error("fill count beyond the window depth");

   a_ptr_bound : assert property (@(posedge clock) disable iff (reset)
      LEN_W'(wp_ff) < LEN_W'(MAX_WINDOW))
      else $error("write pointer beyond the window depth");

   a_record_clear : assert property (@(posedge clock) disable iff (reset)
      (advance && last_ff) |=> (fill_ff == '0 && wp_ff == '0 && sum_ff == '0 && fresh_ff))
      else $error("record state not cleared after the last sample");

   a_accept_to_sum : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SUM))
      else $error("accepted sample did not enter the sum update");
`endif

endmodule
